/* sv/msp_pkg.sv */
// Shared types, constants and the power-of-ten table for the byte-size parser.
// No dependencies.
package msp_pkg;

  localparam int MaxFractionDigits = 19;
  localparam int CountWidth = 5;
  localparam int WordWidth = 64;
  localparam int QuotWidth = 31;

  typedef enum logic [1:0] {
    PH_INT    = 2'd0,
    PH_FRAC   = 2'd1,
    PH_SUFFIX = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_PREP   = 2'd1,
    ST_DIVIDE = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic absorb;
    logic load_div;
    logic div_step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic [WordWidth-1:0] pow_ten(input logic [CountWidth-1:0] n);
    logic [WordWidth-1:0] p;
    case (n)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      default: p = 64'd10000000000000000000;
    endcase
    return p;
  endfunction

endpackage

/* sv/msp_ctrl.sv */
// Controller for the byte-size parser: sequences accept, divide and result write.
// Depends on msp_pkg.
module msp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             is_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  msp_pkg::status_t status,
  output msp_pkg::cmd_t    cmd
);

  msp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msp_pkg::ST_ACCEPT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.write_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      msp_pkg::ST_ACCEPT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.absorb = 1'b1;
          if (is_last) state_next = msp_pkg::ST_PREP;
        end
      end
      msp_pkg::ST_PREP: begin
        cmd.load_div = 1'b1;
        state_next = msp_pkg::ST_DIVIDE;
      end
      msp_pkg::ST_DIVIDE: begin
        if (status.div_done) state_next = msp_pkg::ST_FINISH;
        else cmd.div_step = 1'b1;
      end
      msp_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.write_out = 1'b1;
          state_next = msp_pkg::ST_ACCEPT;
        end
      end
      default: state_next = msp_pkg::ST_ACCEPT;
    endcase
  end

endmodule

/* sv/msp_dpath.sv */
// Datapath for the byte-size parser: accumulators, suffix decode, fraction
// scaling by shift-and-subtract, result register. Depends on msp_pkg.
module msp_dpath #(
  parameter int MAX_FRACTION_DIGITS = msp_pkg::MaxFractionDigits
) (
  input  logic             clk,
  input  logic             rst,
  input  msp_pkg::cmd_t    cmd,
  output msp_pkg::status_t status,
  input  logic [7:0]       char_code,
  output logic [63:0]      byte_count,
  output logic             parse_error
);

  localparam int W = msp_pkg::WordWidth;
  localparam int CW = msp_pkg::CountWidth;
  localparam int QW = msp_pkg::QuotWidth;

  msp_pkg::phase_t  parse_phase;
  logic [W-1:0]     whole_accumulator;
  logic [W-1:0]     fraction_accumulator;
  logic [CW-1:0]    fraction_digit_count;
  logic             dropped_nonzero;
  logic             numeric_seen;
  logic [1:0]       suffix_count;
  logic [7:0]       suffix_first;
  logic [7:0]       suffix_second;
  logic             error_sticky;

  logic [W-1:0]     rem;
  logic [W-1:0]     den;
  logic [QW-1:0]    quot;
  logic [CW-1:0]    div_count;
  logic [CW-1:0]    shift_amt;

  logic             is_digit;
  logic [3:0]       digit;
  logic [W+3:0]     whole_mul;
  logic [W-1:0]     frac_mul;
  logic             suffix_bad;
  logic             first_b;
  logic             second_b;
  logic             first_ok;
  logic [CW-1:0]    first_shift;
  logic [W:0]       rem_shl;
  logic             take;
  logic [W-1:0]     quot_up;
  logic [W-1:0]     base;
  logic             base_ovf;
  logic [W:0]       total;
  logic             result_bad;

  assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign digit = is_digit ? 4'(char_code - 8'h30) : 4'd0;
  assign whole_mul = ({4'd0, whole_accumulator} << 3) + ({4'd0, whole_accumulator} << 1)
                     + (W+4)'(digit);
  assign frac_mul = (fraction_accumulator << 3) + (fraction_accumulator << 1) + W'(digit);

  always_comb begin
    first_ok = 1'b1;
    first_shift = '0;
    case (suffix_first)
      8'h62, 8'h42: first_shift = 5'd0;
      8'h6b, 8'h4b: first_shift = 5'd10;
      8'h6d, 8'h4d: first_shift = 5'd20;
      8'h67, 8'h47: first_shift = 5'd30;
      default: first_ok = 1'b0;
    endcase
  end

  assign first_b = (suffix_first == 8'h62) || (suffix_first == 8'h42);
  assign second_b = (suffix_second == 8'h62) || (suffix_second == 8'h42);

  always_comb begin
    suffix_bad = 1'b0;
    shift_amt = '0;
    case (suffix_count)
      2'd0: shift_amt = '0;
      2'd1: begin
        suffix_bad = !first_ok;
        shift_amt = first_shift;
      end
      2'd2: begin
        suffix_bad = !first_ok || !second_b || first_b;
        shift_amt = first_shift;
      end
      default: suffix_bad = 1'b1;
    endcase
  end

  assign rem_shl = {rem, 1'b0};
  assign take = rem_shl >= {1'b0, den};
  assign status.div_done = (div_count == '0);

  assign quot_up = W'(quot) + W'(((rem != '0) || dropped_nonzero) ? 1'b1 : 1'b0);
  assign base = whole_accumulator << shift_amt;
  assign base_ovf = whole_accumulator > ({W{1'b1}} >> shift_amt);
  assign total = {1'b0, base} + {1'b0, quot_up};
  assign result_bad = error_sticky || !numeric_seen || suffix_bad || base_ovf || total[W];

  always_ff @(posedge clk) begin
    if (rst || cmd.write_out) begin
      parse_phase <= msp_pkg::PH_INT;
      whole_accumulator <= '0;
      fraction_accumulator <= '0;
      fraction_digit_count <= '0;
      dropped_nonzero <= 1'b0;
      numeric_seen <= 1'b0;
      suffix_count <= '0;
      suffix_first <= '0;
      suffix_second <= '0;
      error_sticky <= 1'b0;
    end else if (cmd.absorb) begin
      if (parse_phase == msp_pkg::PH_INT && is_digit) begin
        numeric_seen <= 1'b1;
        if (whole_mul[W+3:W] != '0) error_sticky <= 1'b1;
        else whole_accumulator <= whole_mul[W-1:0];
      end else if (parse_phase == msp_pkg::PH_INT && char_code == 8'h2e) begin
        numeric_seen <= 1'b1;
        parse_phase <= msp_pkg::PH_FRAC;
      end else if (parse_phase == msp_pkg::PH_FRAC && is_digit) begin
        if (fraction_digit_count < CW'(MAX_FRACTION_DIGITS)) begin
          fraction_accumulator <= frac_mul;
          fraction_digit_count <= fraction_digit_count + CW'(1);
        end else if (digit != 4'd0) begin
          dropped_nonzero <= 1'b1;
        end
      end else if (parse_phase == msp_pkg::PH_FRAC && char_code == 8'h2e) begin
        error_sticky <= 1'b1;
      end else begin
        parse_phase <= msp_pkg::PH_SUFFIX;
        if (suffix_count == 2'd0) suffix_first <= char_code;
        if (suffix_count == 2'd1) suffix_second <= char_code;
        if (suffix_count != 2'd3) suffix_count <= suffix_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (cmd.load_div) begin
      div_count <= shift_amt;
    end else if (cmd.div_step) begin
      div_count <= div_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      rem <= fraction_accumulator;
      den <= msp_pkg::pow_ten(fraction_digit_count);
      quot <= '0;
    end else if (cmd.div_step) begin
      rem <= take ? W'(rem_shl - {1'b0, den}) : rem_shl[W-1:0];
      quot <= {quot[QW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      byte_count <= result_bad ? '0 : total[W-1:0];
      parse_error <= result_bad;
    end
  end

endmodule

/* sv/memory_size_string_parser_core.sv */
// Top level of the byte-size text parser: controller plus datapath.
// Depends on msp_pkg, msp_ctrl, msp_dpath.
//
// Input channel (in_valid/in_ready): one ASCII character per beat, with
// is_last on the final character of a token. Output channel
// (out_valid/out_ready): one beat per token with byte_count, the size rounded
// up (zero on error), and parse_error.
// Characters other than the last are taken one per cycle. After the last
// beat the block runs a prep state, one shift-and-subtract step per bit of
// suffix scale (0, 10, 20 or 30), a state that sees the steps done, and a
// write state; the write loads the output register and out_valid, and the
// next token's first character can be taken as the new result is shown.
// The result sits in an output register; if the receiver stalls, a following
// token is still parsed and waits only at its write cycle until the
// register is free.
// Reset (rst, synchronous) clears all parse state and drops out_valid.
module memory_size_string_parser_core #(
  parameter int MAX_FRACTION_DIGITS = msp_pkg::MaxFractionDigits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] byte_count,
  output logic        parse_error
);

  msp_pkg::cmd_t    cmd;
  msp_pkg::status_t status;

  msp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  msp_dpath #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .char_code   (char_code),
    .byte_count  (byte_count),
    .parse_error (parse_error)
  );

endmodule

/* tb/memory_size_string_parser_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for memory_size_string_parser_core: directed, then random tokens,
// checked against listed results or a behavioral predictor. Depends on msp_pkg and the core.
module memory_size_string_parser_core_tb;

  localparam int RandomBeats = 540;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic [63:0] count;
    logic        err;
  } size_result_t;

  typedef struct {
    bit           typed;
    size_result_t result;
  } token_note_t;

  typedef struct {
    string       text;
    bit          typed;
    logic [63:0] count;
    logic        err;
  } size_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'd0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] byte_count;
  logic        parse_error;

  memory_size_string_parser_core #(
    .MAX_FRACTION_DIGITS(msp_pkg::MaxFractionDigits)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .is_last(is_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .byte_count(byte_count),
    .parse_error(parse_error)
  );

  always #5 clk = ~clk;

  // predictor state for the token in flight
  msp_pkg::phase_t ph = msp_pkg::PH_INT;
  logic [63:0] int_part = '0;
  logic [63:0] frac_part = '0;
  logic [4:0]  frac_digits = '0;
  logic        frac_dropped = 1'b0;
  logic        have_number = 1'b0;
  logic [1:0]  suf_len = '0;
  logic [7:0]  suf_a = '0;
  logic [7:0]  suf_b = '0;
  logic        bad_token = 1'b0;

  size_result_t pending_sizes[$];
  token_note_t  token_notes[$];
  logic [7:0]   token_buf[$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           calm = 1'b0;

  function automatic bit takes_break();
    return !calm && ($urandom_range(99) < 14);
  endfunction

  function automatic bit is_b(input logic [7:0] c);
    return c == "b" || c == "B";
  endfunction

  function automatic int suffix_shift(input logic [7:0] c);
    case (c)
      "b", "B": return 0;
      "k", "K": return 10;
      "m", "M": return 20;
      "g", "G": return 30;
      default: return -1;
    endcase
  endfunction

  task automatic clear_token();
    ph = msp_pkg::PH_INT;
    int_part = '0;
    frac_part = '0;
    frac_digits = '0;
    frac_dropped = 1'b0;
    have_number = 1'b0;
    suf_len = '0;
    suf_a = '0;
    suf_b = '0;
    bad_token = 1'b0;
  endtask

  task automatic take_suffix(input logic [7:0] c);
    ph = msp_pkg::PH_SUFFIX;
    if (suf_len == 2'd0) suf_a = c;
    else if (suf_len == 2'd1) suf_b = c;
    if (suf_len != 2'd3) suf_len = suf_len + 2'd1;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    logic        digit;
    logic [3:0]  d;
    logic [67:0] grown;
    digit = c >= "0" && c <= "9";
    d = digit ? c[3:0] : 4'd0;
    case (ph)
      msp_pkg::PH_INT: begin
        if (digit) begin
          have_number = 1'b1;
          grown = {4'd0, int_part};
          grown = grown * 10 + d;
          if (grown[67:64] != 4'd0) bad_token = 1'b1;
          else int_part = grown[63:0];
        end else if (c == ".") begin
          have_number = 1'b1;
          ph = msp_pkg::PH_FRAC;
        end else begin
          take_suffix(c);
        end
      end
      msp_pkg::PH_FRAC: begin
        if (digit) begin
          if (frac_digits < msp_pkg::MaxFractionDigits) begin
            frac_part = frac_part * 10 + d;
            frac_digits = frac_digits + 5'd1;
          end else if (d != 4'd0) begin
            frac_dropped = 1'b1;
          end
        end else if (c == ".") begin
          bad_token = 1'b1;
        end else begin
          take_suffix(c);
        end
      end
      default: take_suffix(c);
    endcase
  endtask

  // exact ceil(number * 2^shift), or the error result
  function automatic size_result_t token_size();
    size_result_t bad;
    int           shift;
    logic [127:0] den, prod, quot, total;
    bad.count = '0;
    bad.err = 1'b1;
    shift = 0;
    if (bad_token || !have_number) return bad;
    if (suf_len == 2'd1) begin
      shift = suffix_shift(suf_a);
    end else if (suf_len == 2'd2) begin
      if (!is_b(suf_b) || is_b(suf_a)) return bad;
      shift = suffix_shift(suf_a);
    end else if (suf_len == 2'd3) begin
      return bad;
    end
    if (shift < 0) return bad;
    den = 128'd1;
    repeat (frac_digits) den = den * 10;
    prod = {64'd0, frac_part} << shift;
    quot = prod / den;
    if (prod % den != 0 || frac_dropped) quot = quot + 1;
    total = ({64'd0, int_part} << shift) + quot;
    if (total[127:64] != 64'd0) return bad;
    token_size.count = total[63:0];
    token_size.err = 1'b0;
  endfunction

  always @(posedge clk) begin : scoreboard
    size_result_t want;
    token_note_t  note;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_sizes.size() == 0) begin
          $error("unexpected result: byte_count %0d parse_error %0b", byte_count, parse_error);
          mismatches++;
        end else begin
          want = pending_sizes.pop_front();
          if (byte_count !== want.count) begin
            $error("byte_count: expected %0d, got %0d", want.count, byte_count);
            mismatches++;
          end
          if (parse_error !== want.err) begin
            $error("parse_error: expected %0b, got %0b", want.err, parse_error);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        absorb_char(char_code);
        if (is_last) begin
          want = token_size();
          clear_token();
          note = token_notes.pop_front();
          pending_sizes.push_back(note.typed ? note.result : want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("memory_size_string_parser_core regression: fail");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= !rst && !takes_break();

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic drive_beat(input logic [7:0] c, input logic last);
    while (takes_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_token(input bit typed, input logic [63:0] count, input logic err);
    token_note_t note;
    note.typed = typed;
    note.result.count = count;
    note.result.err = err;
    token_notes.push_back(note);
    foreach (token_buf[i]) drive_beat(token_buf[i], i == token_buf.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_sizes.size() != 0);
  endtask

  task automatic push_digits(input int n);
    repeat (n) token_buf.push_back(8'("0" + $urandom_range(9)));
  endtask

  task automatic build_wellformed();
    string letters;
    letters = "bkmgBKMG";
    token_buf.delete();
    push_digits(($urandom_range(9) == 0) ? $urandom_range(21) : $urandom_range(1, 4));
    if ($urandom_range(2) != 0) begin
      token_buf.push_back(".");
      push_digits(($urandom_range(7) == 0) ? $urandom_range(18, 24) : $urandom_range(6));
    end
    if ($urandom_range(4) != 0) begin
      token_buf.push_back(letters[$urandom_range(7)]);
      if ($urandom_range(1) != 0) token_buf.push_back($urandom_range(1) ? "b" : "B");
    end
    if (token_buf.size() == 0) push_digits(1);
  endtask

  task automatic build_random_token();
    string      pool;
    int         kind;
    logic [7:0] c;
    pool = "0123456789..bBkKmMgGq x";
    kind = $urandom_range(99);
    if (kind < 75) begin
      build_wellformed();
    end else if (kind < 90) begin
      build_wellformed();
      c = pool[$urandom_range(pool.len() - 1)];
      token_buf.insert($urandom_range(token_buf.size()), c);
    end else begin
      token_buf.delete();
      repeat ($urandom_range(1, 4)) token_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    size_row_t directed_rows[25];
    int        sent;
    int        tokens;
    directed_rows = '{
      '{"0", 1, 64'd0, 1'b0},
      '{"18446744073709551615", 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
      '{"18446744073709551616", 1, 64'd0, 1'b1},
      '{"1k", 1, 64'd1024, 1'b0},
      '{"1MB", 1, 64'd1048576, 1'b0},
      '{"1gB", 1, 64'd1073741824, 1'b0},
      '{"5b", 1, 64'd5, 1'b0},
      '{".", 1, 64'd0, 1'b0},
      '{"5.", 1, 64'd5, 1'b0},
      '{".5k", 1, 64'd512, 1'b0},
      '{"1.5Kb", 1, 64'd1536, 1'b0},
      '{"1.2.3", 1, 64'd0, 1'b1},
      '{"k", 1, 64'd0, 1'b1},
      '{"1kbb", 1, 64'd0, 1'b1},
      '{"1bb", 1, 64'd0, 1'b1},
      '{"1kx", 1, 64'd0, 1'b1},
      '{"1x", 1, 64'd0, 1'b1},
      '{"1K5", 1, 64'd0, 1'b1},
      '{"12 ", 1, 64'd0, 1'b1},
      '{"1\377", 1, 64'd0, 1'b1},
      '{"\2005", 1, 64'd0, 1'b1},
      '{"17179869184g", 1, 64'd0, 1'b1},
      '{"0.1k", 0, 64'd0, 1'b0},
      '{"1.00000000000000000001", 0, 64'd0, 1'b0},
      '{"17179869183.9999999999999999999g", 0, 64'd0, 1'b0}
    };
    sent = 0;
    tokens = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      token_buf.delete();
      for (int i = 0; i < directed_rows[r].text.len(); i++)
        token_buf.push_back(directed_rows[r].text[i]);
      send_token(directed_rows[r].typed, directed_rows[r].count, directed_rows[r].err);
    end
    wait_drained();

    while (sent < RandomBeats) begin
      calm = tokens >= 40 && tokens < 80;
      build_random_token();
      sent += token_buf.size();
      send_token(1'b0, 64'd0, 1'b0);
      tokens++;
      if (tokens % 60 == 0) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_sizes.size() == 0)
      $display("memory_size_string_parser_core regression: pass");
    else
      $display("memory_size_string_parser_core regression: fail");
    $finish;
  end

endmodule

/* files.f */
sv/msp_pkg.sv
sv/msp_ctrl.sv
sv/msp_dpath.sv
sv/memory_size_string_parser_core.sv
tb/memory_size_string_parser_core_tb.sv
